### rtl/core/queue_stack_sorted_list_unit_defines.svh
// Assertion macros shared by the queue/stack/sorted list unit.
// Included by modules that carry concurrent checks; no other dependencies.
`ifndef QUEUE_STACK_SORTED_LIST_UNIT_DEFINES_SVH
`define QUEUE_STACK_SORTED_LIST_UNIT_DEFINES_SVH

`ifndef SYNTHESIS
`define QSL_ASSERT_IMPLY(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("qsl check failed");
`define QSL_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("qsl check failed");
`else
`define QSL_ASSERT_IMPLY(label, clk, rst_n, ante, cons)
`define QSL_ASSERT_NEXT(label, clk, rst_n, ante, cons)
`endif

`endif

### rtl/core/qsl_pkg.sv
// Types and constants for the queue/stack/sorted list unit.
// No dependencies.
package qsl_pkg;

    localparam int VALUE_W  = 32;
    localparam int STATUS_W = 2;
    localparam int MODE_W   = 2;
    localparam int COUNT_W  = 5;

    typedef logic signed [VALUE_W-1:0] t_value;
    typedef logic [STATUS_W-1:0]       t_status;
    typedef logic [MODE_W-1:0]         t_mode;
    typedef logic [COUNT_W-1:0]        t_count_out;

    localparam logic REQ_STORE    = 1'b0;
    localparam logic REQ_RETRIEVE = 1'b1;

    localparam t_status STATUS_DONE  = 2'd0;
    localparam t_status STATUS_EMPTY = 2'd1;
    localparam t_status STATUS_FULL  = 2'd2;

    localparam t_mode MODE_QUEUE  = 2'd0;
    localparam t_mode MODE_STACK  = 2'd1;
    localparam t_mode MODE_SORTED = 2'd2;

    typedef struct packed {
        logic store_en;
        logic retrieve_en;
        logic mode_stack;
        logic mode_sorted;
    } t_cell_ctrl;

endpackage

### rtl/core/qsl_req_if.sv
// Request channel interface (valid/ready plus request payload).
// Depends on qsl_pkg.
interface qsl_req_if import qsl_pkg::*; ();
    logic   valid;
    logic   ready;
    logic   req_type;
    t_value value;

    modport source (output valid, output req_type, output value, input ready);
    modport sink (input valid, input req_type, input value, output ready);
endinterface

### rtl/core/qsl_rsp_if.sv
// Response channel interface (valid/ready plus result payload).
// Depends on qsl_pkg.
interface qsl_rsp_if import qsl_pkg::*; ();
    logic       valid;
    logic       ready;
    t_status    status;
    t_value     removed_value;
    t_count_out entry_count;

    modport source (output valid, output status, output removed_value,
                    output entry_count, input ready);
    modport sink (input valid, input status, input removed_value,
                  input entry_count, output ready);
endinterface

### rtl/core/qsl_cell.sv
// One list slot: holds an entry and shifts, inserts or loads from neighbors.
// Depends on qsl_pkg.
module qsl_cell import qsl_pkg::*; (
    input  logic       i_clk,
    input  t_cell_ctrl i_ctrl,
    input  t_value     i_value,
    input  t_value     i_left,
    input  t_value     i_right,
    input  logic       i_occupied,
    input  logic       i_prefix,
    output logic       o_prefix,
    output t_value     o_data
);

    t_value r_data;
    t_value n_data;
    logic   w_cond;

    // insertion candidate: free slot, stack front, or first entry greater
    always_comb begin
        if (!i_occupied) begin
            w_cond = 1'b1;
        end else if (i_ctrl.mode_stack) begin
            w_cond = 1'b1;
        end else if (i_ctrl.mode_sorted) begin
            w_cond = (i_value < r_data);
        end else begin
            w_cond = 1'b0;
        end
    end

    assign o_prefix = i_prefix | w_cond;

    always_comb begin
        n_data = r_data;
        if (i_ctrl.retrieve_en) begin
            n_data = i_right;
        end else if (i_ctrl.store_en) begin
            if (i_prefix) begin
                n_data = i_left;
            end else if (w_cond) begin
                n_data = i_value;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_data <= n_data;
    end

    assign o_data = r_data;

endmodule

### rtl/core/queue_stack_sorted_list_unit.sv
// Bounded list engine: queue, stack or ascending sorted (min priority queue).
// Request channel i_req: req_type selects store (value) or retrieve (front).
// Response channel o_rsp: one transaction per request with status, the
// removed front value (0 unless a retrieve succeeded) and the entry count.
// Configuration: i_cfg_we writes i_cfg_wdata into the mode register
// (0 queue, 1 stack, 2 sorted, 3 acts as queue); write only while idle.
// Every slot cell compares and shifts in parallel for each request, and a
// carry chain along the cells picks the insert point.
// The response is registered, so it appears the cycle after acceptance;
// one request per cycle is sustained while the receiver keeps ready high.
// When the receiver stalls, the response register holds and i_req.ready
// drops until the held transaction is taken.
// Reset (i_rst_n low, synchronous) empties the list, sets queue mode and
// clears the response valid flag; entry contents and response payload are not cleared.
// Store on a full list is dropped with status full; retrieve on an empty
// list returns status empty.
// Depends on qsl_pkg, qsl_req_if, qsl_rsp_if, qsl_cell and the defines header.
`include "queue_stack_sorted_list_unit_defines.svh"

module queue_stack_sorted_list_unit import qsl_pkg::*; #(
    parameter int DEPTH = 16
) (
    input  logic         i_clk,
    input  logic         i_rst_n,
    qsl_req_if.sink      i_req,
    qsl_rsp_if.source    o_rsp,
    input  logic         i_cfg_we,
    input  t_mode        i_cfg_wdata
);

    localparam int CNT_W = $clog2(DEPTH + 1);

    logic [CNT_W-1:0] r_count;
    logic [CNT_W-1:0] n_count;
    t_mode            r_mode;
    logic             r_valid;
    t_status          r_status;
    t_status          n_status;
    t_value           r_removed;
    t_value           n_removed;
    t_count_out       r_entry_count;

    logic       w_accept;
    logic       w_full;
    logic       w_empty;
    t_cell_ctrl w_ctrl;
    t_value     w_data [DEPTH];
    logic [DEPTH:0] w_prefix;

    assign w_accept = i_req.valid & i_req.ready;
    assign w_full   = (r_count == CNT_W'(DEPTH));
    assign w_empty  = (r_count == '0);

    assign i_req.ready = !r_valid | o_rsp.ready;

    assign w_ctrl.store_en    = w_accept & (i_req.req_type == REQ_STORE) & !w_full;
    assign w_ctrl.retrieve_en = w_accept & (i_req.req_type == REQ_RETRIEVE) & !w_empty;
    assign w_ctrl.mode_stack  = (r_mode == MODE_STACK);
    assign w_ctrl.mode_sorted = (r_mode == MODE_SORTED);

    assign w_prefix[0] = 1'b0;

    for (genvar gi = 0; gi < DEPTH; gi++) begin : g_cell
        t_value w_left;
        t_value w_right;
        if (gi == 0) begin : g_first
            assign w_left = i_req.value;
        end else begin : g_mid_l
            assign w_left = w_data[gi-1];
        end
        if (gi == DEPTH - 1) begin : g_last
            assign w_right = '0;
        end else begin : g_mid_r
            assign w_right = w_data[gi+1];
        end

        qsl_cell u_cell (
            .i_clk      (i_clk),
            .i_ctrl     (w_ctrl),
            .i_value    (i_req.value),
            .i_left     (w_left),
            .i_right    (w_right),
            .i_occupied (CNT_W'(gi) < r_count),
            .i_prefix   (w_prefix[gi]),
            .o_prefix   (w_prefix[gi+1]),
            .o_data     (w_data[gi])
        );
    end

    always_comb begin
        n_count   = r_count;
        n_status  = STATUS_DONE;
        n_removed = '0;
        if (i_req.req_type == REQ_STORE) begin
            if (w_full) begin
                n_status = STATUS_FULL;
            end else begin
                n_count = r_count + CNT_W'(1);
            end
        end else begin
            if (w_empty) begin
                n_status = STATUS_EMPTY;
            end else begin
                n_count   = r_count - CNT_W'(1);
                n_removed = w_data[0];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
            r_mode  <= MODE_QUEUE;
            r_valid <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                r_mode <= i_cfg_wdata;
            end
            if (w_accept) begin
                r_count <= n_count;
                r_valid <= 1'b1;
            end else if (o_rsp.ready) begin
                r_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_status      <= n_status;
            r_removed     <= n_removed;
            r_entry_count <= COUNT_W'(n_count);
        end
    end

    assign o_rsp.valid         = r_valid;
    assign o_rsp.status        = r_status;
    assign o_rsp.removed_value = r_removed;
    assign o_rsp.entry_count   = r_entry_count;

    `QSL_ASSERT_IMPLY(a_count_bound, i_clk, i_rst_n, 1'b1, r_count <= CNT_W'(DEPTH))
    `QSL_ASSERT_IMPLY(a_chain_free, i_clk, i_rst_n, !w_full, w_prefix[DEPTH])
    `QSL_ASSERT_NEXT(a_full_drop, i_clk, i_rst_n, w_accept && (i_req.req_type == REQ_STORE) && w_full, (r_status == STATUS_FULL) && $stable(r_count))
    `QSL_ASSERT_NEXT(a_empty_rsp, i_clk, i_rst_n, w_accept && (i_req.req_type == REQ_RETRIEVE) && w_empty, (r_status == STATUS_EMPTY) && (r_removed == '0))
    `QSL_ASSERT_NEXT(a_front_out, i_clk, i_rst_n, w_ctrl.retrieve_en, r_removed == $past(w_data[0]))

endmodule

### test/tb_queue_stack_sorted_list_unit.sv
// Testbench for queue_stack_sorted_list_unit: directed and random requests in every list
// discipline, checked against an in-bench list model. Depends on qsl_pkg, qsl_req_if,
// qsl_rsp_if and the unit itself.
module tb_queue_stack_sorted_list_unit;
    import qsl_pkg::*;

    localparam int    LIST_DEPTH     = 16;
    localparam int    IDLE_LIMIT     = 2000;
    localparam int    PHASE_REQS     = 112;
    localparam t_mode MODE_UNUSED    = 2'd3;

    typedef struct packed {
        logic   req_type;
        t_value value;
    } list_req_t;

    typedef struct packed {
        t_status    status;
        t_value     removed_value;
        t_count_out entry_count;
    } list_rsp_t;

    logic  i_clk;
    logic  i_rst_n;
    logic  i_cfg_we;
    t_mode i_cfg_wdata;

    qsl_req_if req_ch ();
    qsl_rsp_if rsp_ch ();

    queue_stack_sorted_list_unit #(.DEPTH(LIST_DEPTH)) dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_req       (req_ch),
        .o_rsp       (rsp_ch),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_wdata (i_cfg_wdata)
    );

    list_req_t queued_requests[$];
    list_rsp_t pending_results[$];
    t_value    list_contents[$];
    t_mode     list_mode_shadow;
    list_req_t cur_req;
    bit        req_busy;
    bit        send_idle;
    bit        rcv_idle;
    int        send_wait;
    int        rcv_wait;
    int        rcv_hold;
    int        idle_cycles;
    int        err_count;

    initial i_clk = 1'b0;
    always #2 i_clk = ~i_clk;

    function automatic list_rsp_t apply_list_request(list_req_t rq);
        list_rsp_t r;
        int        pos;
        r.status        = STATUS_DONE;
        r.removed_value = '0;
        if (rq.req_type == REQ_STORE) begin
            if (list_contents.size() >= LIST_DEPTH) begin
                r.status = STATUS_FULL;
            end else begin
                case (list_mode_shadow)
                    MODE_STACK: begin
                        list_contents.push_front(rq.value);
                    end
                    MODE_SORTED: begin
                        pos = list_contents.size();
                        for (int k = 0; k < list_contents.size(); k++) begin
                            if (list_contents[k] > rq.value) begin
                                pos = k;
                                break;
                            end
                        end
                        list_contents.insert(pos, rq.value);
                    end
                    default: begin
                        list_contents.push_back(rq.value);
                    end
                endcase
            end
        end else begin
            if (list_contents.size() == 0) begin
                r.status = STATUS_EMPTY;
            end else begin
                r.removed_value = list_contents.pop_front();
            end
        end
        r.entry_count = t_count_out'(list_contents.size());
        return r;
    endfunction

    function automatic t_value draw_value();
        case ($urandom_range(0, 3))
            0: return t_value'(int'($urandom_range(0, 8)) - 4);
            1: begin
                case ($urandom_range(0, 3))
                    0: return {1'b0, {(VALUE_W-1){1'b1}}};
                    1: return {1'b1, {(VALUE_W-1){1'b0}}};
                    2: return '0;
                    default: return '1;
                endcase
            end
            default: return t_value'($urandom);
        endcase
    endfunction

    task automatic add_request(logic kind, t_value v);
        list_req_t rq;
        rq.req_type = kind;
        rq.value    = v;
        queued_requests.push_back(rq);
    endtask

    task automatic wait_drained();
        @(negedge i_clk);
        while (queued_requests.size() != 0 || req_busy || pending_results.size() != 0) begin
            @(negedge i_clk);
        end
        repeat (2) @(posedge i_clk);
    endtask

    task automatic write_mode(t_mode m);
        wait_drained();
        i_cfg_we         <= 1'b1;
        i_cfg_wdata      <= m;
        list_mode_shadow  = m;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        @(negedge i_clk);
    endtask

    // request driver
    always @(posedge i_clk) begin
        bit offer;
        if (!i_rst_n) begin
            req_ch.valid <= 1'b0;
            req_busy      = 1'b0;
            send_wait     = 0;
        end else begin
            offer = req_busy;
            if (req_busy && req_ch.ready) begin
                pending_results.push_back(apply_list_request(cur_req));
                offer = 1'b0;
            end
            if (!offer) begin
                if (send_wait > 0) begin
                    send_wait--;
                end else if (queued_requests.size() != 0) begin
                    cur_req          = queued_requests.pop_front();
                    req_ch.req_type <= cur_req.req_type;
                    req_ch.value    <= cur_req.value;
                    offer            = 1'b1;
                    send_wait        = send_idle ? $urandom_range(0, 15) : 0;
                end
            end
            req_busy      = offer;
            req_ch.valid <= offer;
        end
    end

    // response monitor
    always @(posedge i_clk) begin
        list_rsp_t want;
        if (!i_rst_n) begin
            rsp_ch.ready <= 1'b0;
            rcv_wait      = 0;
        end else begin
            if (rsp_ch.valid && rsp_ch.ready) begin
                if (pending_results.size() == 0) begin
                    err_count++;
                    $display("%0t: unexpected transaction status %0d removed %0d count %0d",
                             $time, rsp_ch.status, rsp_ch.removed_value, rsp_ch.entry_count);
                end else begin
                    want = pending_results.pop_front();
                    if (rsp_ch.status !== want.status) begin
                        err_count++;
                        $display("%0t: status expected %0d actual %0d",
                                 $time, want.status, rsp_ch.status);
                    end
                    if (rsp_ch.removed_value !== want.removed_value) begin
                        err_count++;
                        $display("%0t: removed_value expected %0d actual %0d",
                                 $time, want.removed_value, rsp_ch.removed_value);
                    end
                    if (rsp_ch.entry_count !== want.entry_count) begin
                        err_count++;
                        $display("%0t: entry_count expected %0d actual %0d",
                                 $time, want.entry_count, rsp_ch.entry_count);
                    end
                end
                rcv_wait = rcv_idle ? $urandom_range(0, 15) : 0;
            end
            if (rcv_hold > 0) begin
                rcv_hold--;
                rsp_ch.ready <= 1'b0;
            end else if (rcv_wait > 0) begin
                rcv_wait--;
                rsp_ch.ready <= 1'b0;
            end else begin
                rsp_ch.ready <= 1'b1;
            end
        end
    end

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            idle_cycles = 0;
        end else if ((req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready)) begin
            idle_cycles = 0;
        end else begin
            idle_cycles++;
            if (idle_cycles == IDLE_LIMIT) begin
                $display("Regression FAIL");
                $finish;
            end
        end
    end

    initial begin
        t_mode mode_seq [12];
        int    store_pct;
        mode_seq = '{MODE_SORTED, MODE_STACK, MODE_UNUSED, MODE_QUEUE, MODE_SORTED,
                     MODE_STACK, MODE_QUEUE, MODE_SORTED, MODE_UNUSED, MODE_STACK,
                     MODE_SORTED, MODE_QUEUE};
        i_rst_n          = 1'b0;
        i_cfg_we         = 1'b0;
        i_cfg_wdata      = MODE_QUEUE;
        req_ch.valid     = 1'b0;
        req_ch.req_type  = REQ_STORE;
        req_ch.value     = '0;
        rsp_ch.ready     = 1'b0;
        list_mode_shadow = MODE_QUEUE;
        send_idle        = 1'b1;
        rcv_idle         = 1'b1;
        rcv_hold         = 0;
        err_count        = 0;
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed: empty retrieve and value extremes in queue mode
        write_mode(MODE_QUEUE);
        add_request(REQ_RETRIEVE, '1);
        add_request(REQ_STORE, {1'b0, {(VALUE_W-1){1'b1}}});
        add_request(REQ_STORE, {1'b1, {(VALUE_W-1){1'b0}}});
        add_request(REQ_STORE, '0);
        add_request(REQ_STORE, '1);
        add_request(REQ_RETRIEVE, '0);
        // sorted inserts over entries left from queue mode, equal values go after
        write_mode(MODE_SORTED);
        add_request(REQ_STORE, '0);
        add_request(REQ_STORE, '1);
        add_request(REQ_RETRIEVE, '0);
        write_mode(MODE_STACK);
        add_request(REQ_STORE, t_value'(5));
        add_request(REQ_RETRIEVE, '0);
        // unused mode, then fill past full
        write_mode(MODE_UNUSED);
        add_request(REQ_STORE, t_value'(9));
        add_request(REQ_RETRIEVE, '0);
        for (int i = 0; i < LIST_DEPTH - 3; i++) begin
            add_request(REQ_STORE, t_value'($urandom));
        end

        for (int p = 0; p < 12; p++) begin
            write_mode(mode_seq[p]);
            send_idle = ($urandom_range(0, 3) != 0);
            rcv_idle  = ($urandom_range(0, 3) != 0);
            store_pct = $urandom_range(25, 75);
            if (p == 4) begin
                send_idle = 1'b0;
                rcv_idle  = 1'b0;
                rcv_hold  = 120;
                store_pct = 90;
            end
            for (int i = 0; i < PHASE_REQS; i++) begin
                add_request(($urandom_range(1, 100) <= store_pct) ? REQ_STORE : REQ_RETRIEVE,
                            draw_value());
            end
        end

        wait_drained();
        repeat (4) @(posedge i_clk);
        if (err_count == 0) begin
            $display("Regression PASS");
        end else begin
            $display("Regression FAIL");
        end
        $finish;
    end
endmodule
